@@ src/rau_pkg.sv @@
// Package for the rational arithmetic unit: operation codes, field widths and state type.
// Depends on nothing; used by rational_arith_unit_top.sv and the testbench.
`default_nettype none
package rau_pkg;
	localparam int unsigned WIDTH_DEF = 16;
	localparam int unsigned NUM_W = 33;
	localparam int unsigned DEN_W = 32;
	localparam int unsigned OP_W = 3;

	typedef enum logic [OP_W-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_RED = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

@@ src/rau_serial_mul.sv @@
// Shift-and-add multiplier for two signed operands, one multiplier bit per cycle.
// Does not depend on rau_pkg or any other file; stands alone.
`default_nettype none
module rau_serial_mul #(
	parameter int unsigned WIDTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [WIDTH-1:0]     op_x,
	input  wire logic [WIDTH-1:0]     op_y,
	output logic                      done,
	output logic [2*WIDTH-1:0]        prod
);
	localparam int unsigned CW = $clog2(WIDTH + 1);

	logic [2*WIDTH-1:0] mcand_q;
	logic [WIDTH-1:0]   mplier_q;
	logic [2*WIDTH-1:0] acc_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;

	// The multiplicand is sign extended to the product width, so the
	// product is exact modulo 2^(2*WIDTH); the top multiplier bit has negative weight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(WIDTH - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= {{WIDTH{op_x[WIDTH-1]}}, op_x};
			mplier_q <= op_y;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				if (cnt_q == CW'(WIDTH - 1)) begin
					acc_q <= acc_q - mcand_q;
				end else begin
					acc_q <= acc_q + mcand_q;
				end
			end
			mcand_q  <= {mcand_q[2*WIDTH-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[WIDTH-1:1]};
		end
	end

	assign prod = acc_q;
endmodule
`default_nettype wire

@@ src/rau_serial_div.sv @@
// Restoring divider for unsigned magnitudes, one quotient bit per cycle; also yields the remainder.
// Depends on nothing else; used by the top level for the GCD steps and the final reductions.
`default_nettype none
module rau_serial_div #(
	parameter int unsigned WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] dividend,
	input  wire logic [WIDTH-1:0] divisor,
	output logic                  done,
	output logic [WIDTH-1:0]      quot,
	output logic [WIDTH-1:0]      rem
);
	localparam int unsigned CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] q_q;
	logic [WIDTH-1:0] r_q;
	logic [WIDTH-1:0] d_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   shifted;

	assign shifted = {r_q, q_q[WIDTH-1]};
	assign trial   = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(WIDTH - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// The partial remainder stays below the divisor, so WIDTH bits hold it.
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[WIDTH]) begin
				r_q <= trial[WIDTH-1:0];
				q_q <= {q_q[WIDTH-2:0], 1'b1};
			end else begin
				r_q <= shifted[WIDTH-1:0];
				q_q <= {q_q[WIDTH-2:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
	assign rem  = r_q;
endmodule
`default_nettype wire

@@ src/rational_arith_unit_top.sv @@
// Top level of the rational arithmetic unit: sequencer, operand registers and result register.
// Depends on rau_pkg, rau_serial_mul and rau_serial_div.
`default_nettype none
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  input   | valid_in/ready_in, operation, num_a..den_b      | into unit
//  output  | valid_out/ready_out, res_num, res_den, den_zero | out of unit
//
// One word is handled at a time. Each product runs on the bit-serial multiplier;
// multiply and divide need two products, add and subtract need three.
// Reduce runs Euclid on the shared serial divider, one division per remainder step
// (at most about 1.5*WIDTH steps), then two more divisions for the quotients.
// Reset clears the sequencer and the output valid; payload registers are not reset.
// A result waiting at the output does not block acceptance of the next word; the unit
// waits in DONE only when that word finishes before the earlier result has been taken.
module rational_arith_unit_top #(
	parameter int unsigned WIDTH = rau_pkg::WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      valid_in,
	output logic                           ready_in,
	input  wire logic [rau_pkg::OP_W-1:0]  operation,
	input  wire logic signed [WIDTH-1:0]   num_a,
	input  wire logic signed [WIDTH-1:0]   den_a,
	input  wire logic signed [WIDTH-1:0]   num_b,
	input  wire logic signed [WIDTH-1:0]   den_b,
	output logic                           valid_out,
	input  wire logic                      ready_out,
	output logic signed [rau_pkg::NUM_W-1:0] res_num,
	output logic signed [rau_pkg::DEN_W-1:0] res_den,
	output logic                           den_zero
);
	localparam int unsigned PW = 2 * WIDTH;
	localparam int unsigned NW = rau_pkg::NUM_W;
	localparam int unsigned DW = rau_pkg::DEN_W;

	rau_pkg::state_t state_q, state_d;

	logic [rau_pkg::OP_W-1:0] op_q;
	logic [WIDTH-1:0] na_q, da_q, nb_q, db_q;
	logic [PW:0]      t1_q;        // first product, one bit wider for the sum
	logic [PW-1:0]    p2_q;        // denominator product of add and subtract
	logic [WIDTH-1:0] gx_q, gy_q;  // Euclid pair
	logic [WIDTH-1:0] qn_q;
	// Add and subtract need a third product; a sub-phase flag tells it apart.
	logic             third_q;

	logic             mul_start, mul_done;
	logic [WIDTH-1:0] mul_x, mul_y;
	logic [PW-1:0]    prod;
	logic             div_start, div_done;
	logic [WIDTH-1:0] div_a, div_b, quot, rem;

	logic [WIDTH-1:0] mag_na, mag_da;
	logic             accept, out_free, red_trivial;
	logic [PW:0]      prod_x, sum_v;
	logic [NW-1:0]    num_v;
	logic [DW-1:0]    den_v;
	logic             load_out;

	assign mag_na = na_q[WIDTH-1] ? WIDTH'(-na_q) : na_q;
	assign mag_da = da_q[WIDTH-1] ? WIDTH'(-da_q) : da_q;
	assign out_free = !valid_out || ready_out;
	assign ready_in = (state_q == rau_pkg::ST_IDLE);
	assign accept = valid_in && ready_in;
	assign red_trivial = (na_q == '0) || (da_q == '0);
	assign prod_x = {prod[PW-1], prod};
	assign sum_v = (op_q == rau_pkg::OP_SUB) ? (t1_q - prod_x) : (t1_q + prod_x);

	rau_serial_mul #(.WIDTH(WIDTH)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .op_x(mul_x), .op_y(mul_y),
		.done(mul_done), .prod(prod)
	);

	rau_serial_div #(.WIDTH(WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
		.done(div_done), .quot(quot), .rem(rem)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rau_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = rau_pkg::ST_MUL1;
				end
			end
			rau_pkg::ST_MUL1: begin
				// The first cycle after acceptance starts the work for the operation.
				case (op_q)
					rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL,
					rau_pkg::OP_DIV: state_d = rau_pkg::ST_MUL2;
					rau_pkg::OP_RED: state_d = red_trivial ? rau_pkg::ST_DONE
						: rau_pkg::ST_GCD;
					default: state_d = rau_pkg::ST_DONE;
				endcase
			end
			rau_pkg::ST_MUL2: begin
				if (mul_done) begin
					state_d = rau_pkg::ST_MUL3;
				end
			end
			rau_pkg::ST_MUL3: begin
				if (mul_done) begin
					state_d = (!third_q
						&& (op_q == rau_pkg::OP_ADD || op_q == rau_pkg::OP_SUB))
						? rau_pkg::ST_MUL3 : rau_pkg::ST_DONE;
				end
			end
			rau_pkg::ST_GCD: begin
				if (div_done && rem == '0) begin
					state_d = rau_pkg::ST_DIVN;
				end
			end
			rau_pkg::ST_DIVN: begin
				if (div_done) begin
					state_d = rau_pkg::ST_DIVD;
				end
			end
			rau_pkg::ST_DIVD: begin
				if (div_done) begin
					state_d = rau_pkg::ST_DONE;
				end
			end
			rau_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = rau_pkg::ST_IDLE;
				end
			end
			default: state_d = rau_pkg::ST_IDLE;
		endcase
	end

	// Output logic for the shared units: which operands go in and when they start.
	always_comb begin
		mul_start = 1'b0;
		mul_x     = na_q;
		mul_y     = db_q;
		div_start = 1'b0;
		div_a     = gx_q;
		div_b     = gy_q;
		case (state_q)
			rau_pkg::ST_MUL1: begin
				mul_start = (op_q == rau_pkg::OP_ADD) || (op_q == rau_pkg::OP_SUB)
					|| (op_q == rau_pkg::OP_MUL) || (op_q == rau_pkg::OP_DIV);
				mul_y     = (op_q == rau_pkg::OP_MUL) ? nb_q : db_q;
				div_start = (op_q == rau_pkg::OP_RED) && !red_trivial;
				div_a     = mag_na;
				div_b     = mag_da;
			end
			rau_pkg::ST_MUL2: begin
				mul_start = mul_done;
				mul_x     = da_q;
				mul_y     = (op_q == rau_pkg::OP_DIV) ? nb_q : db_q;
			end
			rau_pkg::ST_MUL3: begin
				mul_start = mul_done && !third_q
					&& (op_q == rau_pkg::OP_ADD || op_q == rau_pkg::OP_SUB);
				mul_x     = nb_q;
				mul_y     = da_q;
			end
			rau_pkg::ST_GCD: begin
				// Continue Euclid with (divisor, remainder), or start the numerator division.
				div_start = div_done;
				div_a     = (rem == '0) ? mag_na : gy_q;
				div_b     = (rem == '0) ? gy_q : rem;
			end
			rau_pkg::ST_DIVN: begin
				div_start = div_done;
				div_a     = mag_da;
				div_b     = gx_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rau_pkg::ST_IDLE;
			valid_out <= 1'b0;
			third_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rau_pkg::ST_MUL1) begin
				third_q <= 1'b0;
			end else if (state_q == rau_pkg::ST_MUL3 && mul_done) begin
				third_q <= 1'b1;
			end
			if (load_out) begin
				valid_out <= 1'b1;
			end else if (ready_out) begin
				valid_out <= 1'b0;
			end
		end
	end

	// Result assembly for the finishing cycle.
	always_comb begin
		num_v = '0;
		den_v = '0;
		case (op_q)
			rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
				num_v = NW'({{NW{sum_v[PW]}}, sum_v});
				den_v = DW'({{DW{p2_q[PW-1]}}, p2_q});
			end
			rau_pkg::OP_MUL, rau_pkg::OP_DIV: begin
				num_v = NW'({{NW{t1_q[PW]}}, t1_q});
				den_v = DW'({{DW{prod[PW-1]}}, prod});
			end
			rau_pkg::OP_RED: begin
				if (red_trivial) begin
					num_v = NW'({{NW{na_q[WIDTH-1]}}, na_q});
					den_v = DW'({{DW{da_q[WIDTH-1]}}, da_q});
				end else begin
					num_v = na_q[WIDTH-1] ? -(NW'({1'b0, qn_q})) : NW'({1'b0, qn_q});
					den_v = da_q[WIDTH-1] ? -(DW'({1'b0, quot})) : DW'({1'b0, quot});
				end
			end
			default: begin
			end
		endcase
	end

	// The result register is loaded once, in DONE, when it is free.
	logic [NW-1:0] num_hold_q;
	logic [DW-1:0] den_hold_q;
	assign load_out = (state_q == rau_pkg::ST_DONE) && out_free;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= operation;
			na_q <= num_a;
			da_q <= den_a;
			nb_q <= num_b;
			db_q <= den_b;
		end
		// Capture the finished values on entering DONE; they stay put there.
		if (state_q != rau_pkg::ST_DONE && state_d == rau_pkg::ST_DONE) begin
			num_hold_q <= num_v;
			den_hold_q <= den_v;
		end
		if (state_q == rau_pkg::ST_MUL2 && mul_done) begin
			t1_q <= {prod[PW-1], prod};
		end
		if (state_q == rau_pkg::ST_MUL3 && mul_done && !third_q) begin
			p2_q <= prod;
		end
		if (state_q == rau_pkg::ST_MUL1) begin
			gx_q <= mag_na;
			gy_q <= mag_da;
		end else if (state_q == rau_pkg::ST_GCD && div_done) begin
			gx_q <= gy_q;
			gy_q <= rem;
		end
		if (state_q == rau_pkg::ST_DIVN && div_done) begin
			qn_q <= quot;
		end
		if (load_out) begin
			res_num  <= num_hold_q;
			res_den  <= den_hold_q;
			den_zero <= (den_hold_q == '0);
		end
	end
endmodule
`default_nettype wire

@@ tb/sv/rational_arith_unit_top_test.sv @@
// Self-checking bench for the rational arithmetic unit: drives random and corner-case words,
// predicts each result in place and compares it field by field. Depends on rau_pkg and the RTL.
`default_nettype none
module rational_arith_unit_top_test;
	localparam int W = 16;
	localparam int STALL_LIMIT = 20000;
	localparam int OPW = rau_pkg::OP_W;
	localparam int NUMW = rau_pkg::NUM_W;
	localparam int DENW = rau_pkg::DEN_W;

	typedef struct {
		logic signed [NUMW-1:0] num;
		logic signed [DENW-1:0] den;
		logic                   dz;
	} frac_res_t;

	logic clk;
	logic arst_n;
	logic valid_in;
	logic ready_in;
	logic [OPW-1:0] operation;
	logic signed [W-1:0] num_a, den_a, num_b, den_b;
	logic valid_out;
	logic ready_out;
	logic signed [NUMW-1:0] res_num;
	logic signed [DENW-1:0] res_den;
	logic den_zero;

	rational_arith_unit_top #(.WIDTH(W)) dut (
		.clk(clk), .arst_n(arst_n),
		.valid_in(valid_in), .ready_in(ready_in),
		.operation(operation), .num_a(num_a), .den_a(den_a),
		.num_b(num_b), .den_b(den_b),
		.valid_out(valid_out), .ready_out(ready_out),
		.res_num(res_num), .res_den(res_den), .den_zero(den_zero)
	);

	// Results still owed by the unit, oldest first.
	frac_res_t pending_results[$];
	int  fail_count = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  recv_hold = 0;
	int  quiet_cycles = 0;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Computes the expected fraction at 64 bits, then masks to the output widths.
	function automatic frac_res_t rational_result(logic [OPW-1:0] op,
			logic signed [W-1:0] na, logic signed [W-1:0] da,
			logic signed [W-1:0] nb, logic signed [W-1:0] db);
		longint rn, rd, x, y, t, mn, md;
		frac_res_t r;
		rn = 0;
		rd = 0;
		case (op)
			rau_pkg::OP_ADD: begin
				rn = longint'(na) * db + longint'(nb) * da;
				rd = longint'(da) * db;
			end
			rau_pkg::OP_SUB: begin
				rn = longint'(na) * db - longint'(nb) * da;
				rd = longint'(da) * db;
			end
			rau_pkg::OP_MUL: begin
				rn = longint'(na) * nb;
				rd = longint'(da) * db;
			end
			rau_pkg::OP_DIV: begin
				rn = longint'(na) * db;
				rd = longint'(da) * nb;
			end
			rau_pkg::OP_RED: begin
				rn = na;
				rd = da;
				if (na != 0 && da != 0) begin
					mn = (na < 0) ? -longint'(na) : longint'(na);
					md = (da < 0) ? -longint'(da) : longint'(da);
					x = mn;
					y = md;
					while (y != 0) begin
						t = x % y;
						x = y;
						y = t;
					end
					rn = (na < 0) ? -(mn / x) : mn / x;
					rd = (da < 0) ? -(md / x) : md / x;
				end
			end
			default: begin
				rn = 0;
				rd = 0;
			end
		endcase
		r.num = rn[NUMW-1:0];
		r.den = rd[DENW-1:0];
		r.dz = (r.den == 0);
		return r;
	endfunction

	// Offers one word, with a random gap first, and waits for its acceptance.
	task automatic send_word(logic [OPW-1:0] op, logic signed [W-1:0] na,
			logic signed [W-1:0] da, logic signed [W-1:0] nb, logic signed [W-1:0] db);
		while ($urandom_range(99) < send_idle_pct) begin
			valid_in <= 1'b0;
			@(posedge clk);
		end
		valid_in <= 1'b1;
		operation <= op;
		num_a <= na;
		den_a <= da;
		num_b <= nb;
		den_b <= db;
		@(posedge clk);
		while (!ready_in)
			@(posedge clk);
		pending_results.push_back(rational_result(op, na, da, nb, db));
	endtask

	// Receiver: ready goes low at random, or for as long as a hold-off lasts.
	always @(posedge clk) begin
		if (!arst_n) begin
			ready_out <= 1'b0;
		end else begin
			ready_out <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Checks each accepted result against the oldest prediction.
	always @(posedge clk) begin
		frac_res_t e;
		if (arst_n && valid_out && ready_out) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: num %0d den %0d", res_num, res_den);
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				if (res_num !== e.num) begin
					$error("res_num expected %0d actual %0d", e.num, res_num);
					fail_count++;
				end
				if (res_den !== e.den) begin
					$error("res_den expected %0d actual %0d", e.den, res_den);
					fail_count++;
				end
				if (den_zero !== e.dz) begin
					$error("den_zero expected %0d actual %0d", e.dz, den_zero);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if ((valid_in && ready_in) || (valid_out && ready_out))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[rational_arith_unit_top] ERROR");
			$finish;
		end
	end

	function automatic logic signed [W-1:0] rand_field();
		case ($urandom_range(5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return W'($urandom_range(8)) - 16'sd4;
			default: return W'($urandom);
		endcase
	endfunction

	// Drops the offer and waits until every predicted result has come back.
	task automatic drain();
		valid_in <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_corners();
		logic [W-1:0] ext[4];
		ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
		for (int op = 0; op < 8; op++)
			send_word(op[OPW-1:0], ext[op % 4], ext[(op + 1) % 4],
				ext[(op + 2) % 4], ext[(op + 3) % 4]);
		// Reduce: zero numerator, zero denominator, both negative, most negative pair.
		send_word(rau_pkg::OP_RED, 16'sd0, 16'sd6, 16'sd1, 16'sd1);
		send_word(rau_pkg::OP_RED, 16'sd9, 16'sd0, 16'sd1, 16'sd1);
		send_word(rau_pkg::OP_RED, -16'sd12, -16'sd18, 16'sd1, 16'sd1);
		send_word(rau_pkg::OP_RED, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0);
		send_word(rau_pkg::OP_RED, 16'sh8000, 16'sh7fff, 16'sd0, 16'sd0);
		send_word(rau_pkg::OP_RED, 16'sd28657, 16'sd17711, 16'sd0, 16'sd0);
		// A zero result denominator from divide by a zero numerator.
		send_word(rau_pkg::OP_DIV, 16'sd5, 16'sd3, 16'sd0, 16'sd7);
		send_word(rau_pkg::OP_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_word(rau_pkg::OP_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
		drain();
	endtask

	task automatic test_random(int count);
		logic [OPW-1:0] op;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(15) == 0) ? OPW'($urandom_range(7, 5))
				: OPW'($urandom_range(4));
			send_word(op, rand_field(), rand_field(), rand_field(), rand_field());
		end
	endtask

	// Holds the receiver off for a long stretch so the unit fills and blocks its input.
	task automatic test_backpressure();
		recv_hold = 1;
		fork
			repeat (600) @(posedge clk);
			test_random(6);
		join_any
		recv_hold = 0;
		wait fork;
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		valid_in = 1'b0;
		operation = '0;
		num_a = '0;
		den_a = '0;
		num_b = '0;
		den_b = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		send_idle_pct = 28;
		recv_idle_pct = 58;
		test_random(460);
		drain();
		test_backpressure();
		send_idle_pct = 58;
		recv_idle_pct = 28;
		test_random(460);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(460);
		drain();
		repeat (200) @(posedge clk);

		if (fail_count == 0 && pending_results.size() == 0)
			$display("[rational_arith_unit_top] OK");
		else
			$display("[rational_arith_unit_top] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
